### hdl/spmp_pkg.sv
// Shared constants for the supervisor memory protection checker.
// Field widths, opcodes and encodings; used by the channel interfaces and the top level.
// No dependencies.
package spmp_pkg;

    // Payload field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int WORD_W   = 64;
    localparam int PADDR_W  = 56;
    localparam int SIZE_W   = 7;
    localparam int KIND_W   = 2;
    localparam int PRIV_W   = 2;
    localparam int FCODE_W  = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_CFG = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WR_ADR = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLR_A  = 2'd3;

    // Access kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    // Privilege modes
    localparam logic [PRIV_W-1:0] PRIV_U = 2'd0;
    localparam logic [PRIV_W-1:0] PRIV_S = 2'd1;
    localparam logic [PRIV_W-1:0] PRIV_M = 2'd3;

    // Address matching modes (A field)
    localparam logic [1:0] A_OFF   = 2'd0;
    localparam logic [1:0] A_TOR   = 2'd1;
    localparam logic [1:0] A_NA4   = 2'd2;
    localparam logic [1:0] A_NAPOT = 2'd3;

    // Config byte bit positions
    localparam int CFG_R_BIT  = 0;
    localparam int CFG_W_BIT  = 1;
    localparam int CFG_X_BIT  = 2;
    localparam int CFG_A_LO   = 3;
    localparam int CFG_A_HI   = 4;
    localparam int CFG_S_BIT  = 7;
    localparam int CFG_W_BITS = 8;

    // Fault codes
    localparam logic [FCODE_W-1:0] FC_NONE  = 2'd0;
    localparam logic [FCODE_W-1:0] FC_LOAD  = 2'd1;
    localparam logic [FCODE_W-1:0] FC_STORE = 2'd2;
    localparam logic [FCODE_W-1:0] FC_INSTR = 2'd3;

endpackage

### hdl/spmp_ifs.sv
// Valid/ready channel interfaces for the checker: request in, response out.
// Depends on spmp_pkg for field widths.

interface spmp_req_if;
    logic                              valid;
    logic                              ready;
    logic [spmp_pkg::OPCODE_W-1:0]     opcode;
    logic [spmp_pkg::INDEX_W-1:0]      entry_index;
    logic [spmp_pkg::WORD_W-1:0]       write_value;
    logic [spmp_pkg::PADDR_W-1:0]      phys_addr;
    logic [spmp_pkg::SIZE_W-1:0]       access_size;
    logic [spmp_pkg::KIND_W-1:0]       access_kind;
    logic [spmp_pkg::PRIV_W-1:0]       priv_mode;
    logic                              sum_bit;
    logic [spmp_pkg::WORD_W-1:0]       request_vaddr;
    logic                              has_request_vaddr;
    logic [spmp_pkg::WORD_W-1:0]       fallback_vaddr;

    modport source (
        output valid, opcode, entry_index, write_value, phys_addr, access_size,
               access_kind, priv_mode, sum_bit, request_vaddr, has_request_vaddr,
               fallback_vaddr,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, write_value, phys_addr, access_size,
               access_kind, priv_mode, sum_bit, request_vaddr, has_request_vaddr,
               fallback_vaddr,
        output ready
    );
endinterface

interface spmp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [spmp_pkg::FCODE_W-1:0]      fault_code;
    logic [spmp_pkg::WORD_W-1:0]       fault_addr;

    modport source (output valid, ok, fault_code, fault_addr, input ready);
    modport sink   (input valid, ok, fault_code, fault_addr, output ready);
endinterface

### hdl/supervisor_pmp_checker_top.sv
// Supervisor memory protection checker: entry tables, entry walk sequencer, response register.
// Depends on spmp_pkg, spmp_ifs (spmp_req_if, spmp_rsp_if) and spmp_ram.
//
//  channel  dir  transfer when         payload
//  i_req    in   valid & ready         opcode, entry_index, write_value, access fields
//  o_rsp    out  valid & ready         ok, fault_code, fault_addr
//
// Writes and the clear command go from accept through S_FIN to the response register.
// A check in machine mode or with no enabled entry goes straight to S_FIN; otherwise
// it walks the entries one per cycle through the entry RAM read port,
// ending early at the first matching entry.
// Reset clears all entries at once (per-entry valid bits); no clearing pass.
// A held response does not stop the next request from being taken.
module supervisor_pmp_checker_top #(
    parameter int ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spmp_req_if.sink      i_req,
    spmp_rsp_if.source    o_rsp
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = spmp_pkg::WORD_W;
    localparam int CB = spmp_pkg::CFG_W_BITS;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} t_state;

    t_state                        r_state;
    logic                          r_out_vld;
    logic                          r_out_ok;
    logic [spmp_pkg::FCODE_W-1:0]  r_out_code;
    logic [WW-1:0]                 r_out_addr;

    logic [ENTRIES-1:0]            r_cfg_vld;
    logic [ENTRIES-1:0]            r_adr_vld;
    logic [ENTRIES-1:0]            r_en;

    logic [spmp_pkg::PADDR_W-1:0]  r_first;
    logic [spmp_pkg::PADDR_W:0]    r_last;
    logic [spmp_pkg::KIND_W-1:0]   r_kind;
    logic [spmp_pkg::PRIV_W-1:0]   r_priv;
    logic                          r_sum;
    logic [WW-1:0]                 r_fault_addr;
    logic                          r_is_chk;
    logic                          r_allow;

    logic [CW-1:0]                 r_ridx;
    logic [IW-1:0]                 r_eidx;
    logic                          r_evv;
    logic [WW-1:0]                 r_prev_top;

    logic                          accept;
    logic                          idx_ok;
    logic [IW-1:0]                 widx;
    logic                          cfg_we;
    logic                          adr_we;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    logic [CB-1:0]                 cfg_rdata;
    logic [WW-1:0]                 adr_rdata;
    logic [spmp_pkg::KIND_W-1:0]   in_kind;
    logic [spmp_pkg::PADDR_W:0]    in_last;

    logic [CB-1:0]                 e_cfg;
    logic [1:0]                    e_amode;
    logic [WW-1:0]                 e_word;
    logic [WW-1:0]                 e_top;
    logic [WW-1:0]                 e_ones;
    logic [WW-1:0]                 e_keep;
    logic [WW-1:0]                 x_first;
    logic [WW-1:0]                 x_last;
    logic                          e_hit;
    logic                          out_free;
    logic [spmp_pkg::FCODE_W-1:0]  kind_code;

    // Permission decision for the matching entry
    function automatic logic decide(
        input logic [CB-1:0]                cfg,
        input logic [spmp_pkg::KIND_W-1:0]  kind,
        input logic [spmp_pkg::PRIV_W-1:0]  priv,
        input logic                         sum
    );
        logic [3:0] srwx;
        logic       rd;
        logic       wr;
        logic       ex;
        logic       rwx;
        logic       s_bit;
        logic       res;
        srwx  = {cfg[spmp_pkg::CFG_S_BIT], cfg[spmp_pkg::CFG_R_BIT],
                 cfg[spmp_pkg::CFG_W_BIT], cfg[spmp_pkg::CFG_X_BIT]};
        s_bit = cfg[spmp_pkg::CFG_S_BIT];
        rd    = (kind == spmp_pkg::KIND_READ);
        wr    = (kind == spmp_pkg::KIND_WRITE);
        ex    = !rd && !wr;
        rwx   = rd ? cfg[spmp_pkg::CFG_R_BIT] :
                wr ? cfg[spmp_pkg::CFG_W_BIT] : cfg[spmp_pkg::CFG_X_BIT];
        // shared-region encodings first
        if ((rd || wr) && srwx == 4'h3) begin
            res = 1'b1;
        end else if (priv == spmp_pkg::PRIV_S && (ex || rd) && srwx == 4'hB) begin
            res = 1'b1;
        end else if (priv == spmp_pkg::PRIV_U && ex && srwx == 4'hB) begin
            res = 1'b1;
        end else if (priv == spmp_pkg::PRIV_U && rd && srwx == 4'h2) begin
            res = 1'b1;
        end else if (ex && srwx == 4'hA) begin
            res = 1'b1;
        end else if (priv == spmp_pkg::PRIV_S) begin
            if (s_bit) begin
                res = rwx;
            end else begin
                res = sum && !ex && rwx;
            end
        end else if (priv == spmp_pkg::PRIV_U) begin
            res = !s_bit && rwx;
        end else begin
            res = 1'b0;
        end
        return res;
    endfunction

    // Request side
    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign idx_ok      = ({1'b0, i_req.entry_index} < 7'(ENTRIES));
    assign widx        = i_req.entry_index[IW-1:0];
    assign cfg_we      = accept && (i_req.opcode == spmp_pkg::OP_WR_CFG) && idx_ok;
    assign adr_we      = accept && (i_req.opcode == spmp_pkg::OP_WR_ADR) && idx_ok;
    assign in_kind     = (i_req.access_kind == spmp_pkg::KIND_RSVD) ? spmp_pkg::KIND_EXEC
                                                                    : i_req.access_kind;
    // last byte; a zero size counts as one byte
    assign in_last     = {1'b0, i_req.phys_addr}
                       + ((i_req.access_size == '0) ? '0
                          : (spmp_pkg::PADDR_W + 1)'(i_req.access_size - 7'd1));

    // Entry tables
    assign rd_en   = (r_state == S_WALK) && (r_ridx < CW'(ENTRIES));
    assign rd_addr = r_ridx[IW-1:0];

    spmp_ram #(.WIDTH(CB), .DEPTH(ENTRIES)) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (cfg_we),
        .i_waddr (widx),
        .i_wdata (i_req.write_value[CB-1:0]),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (cfg_rdata)
    );

    spmp_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_adr_ram (
        .i_clk   (i_clk),
        .i_we    (adr_we),
        .i_waddr (widx),
        .i_wdata (i_req.write_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (adr_rdata)
    );

    // Region match for the entry under evaluation
    assign e_cfg   = r_cfg_vld[r_eidx] ? cfg_rdata : '0;
    assign e_amode = r_en[r_eidx] ? e_cfg[spmp_pkg::CFG_A_HI:spmp_pkg::CFG_A_LO]
                                  : spmp_pkg::A_OFF;
    assign e_word  = r_adr_vld[r_eidx] ? adr_rdata : '0;
    assign e_top   = {e_word[WW-3:0], 2'b00};
    // trailing ones plus the first zero bit
    assign e_ones  = e_word ^ (e_word + WW'(1));
    assign e_keep  = ~{e_ones[WW-3:0], 2'b11};
    assign x_first = WW'(r_first);
    assign x_last  = WW'(r_last);

    always_comb begin
        case (e_amode)
            spmp_pkg::A_TOR:   e_hit = (x_first >= r_prev_top) && (x_last < e_top);
            spmp_pkg::A_NA4:   e_hit = ({x_first[WW-1:2], 2'b00} == e_top)
                                    && ({x_last[WW-1:2], 2'b00} == e_top);
            spmp_pkg::A_NAPOT: e_hit = (((x_first ^ e_top) & e_keep) == '0)
                                    && (((x_last ^ e_top) & e_keep) == '0);
            default:           e_hit = 1'b0;
        endcase
    end

    // Fault code for the stored access kind
    always_comb begin
        case (r_kind)
            spmp_pkg::KIND_READ:  kind_code = spmp_pkg::FC_LOAD;
            spmp_pkg::KIND_WRITE: kind_code = spmp_pkg::FC_STORE;
            default:              kind_code = spmp_pkg::FC_INSTR;
        endcase
    end

    assign out_free = !r_out_vld || o_rsp.ready;

    // Sequencer, entry valid bits and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_cfg_vld <= '0;
            r_adr_vld <= '0;
            r_en      <= '0;
            r_evv     <= 1'b0;
        end else begin
            // response valid: set when a result is loaded, cleared on its transfer
            if (r_state == S_FIN && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req.opcode)
                            spmp_pkg::OP_CHECK: begin
                                r_is_chk     <= 1'b1;
                                r_first      <= i_req.phys_addr;
                                r_last       <= in_last;
                                r_kind       <= in_kind;
                                r_priv       <= i_req.priv_mode;
                                r_sum        <= i_req.sum_bit;
                                r_fault_addr <= i_req.has_request_vaddr ? i_req.request_vaddr
                                                                        : i_req.fallback_vaddr;
                                if (i_req.priv_mode == spmp_pkg::PRIV_M || r_en == '0) begin
                                    r_allow <= 1'b1;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state    <= S_WALK;
                                    r_ridx     <= '0;
                                    r_evv      <= 1'b0;
                                    r_prev_top <= '0;
                                end
                            end
                            spmp_pkg::OP_WR_CFG: begin
                                r_is_chk <= 1'b0;
                                r_state  <= S_FIN;
                                r_allow  <= idx_ok;
                                if (idx_ok) begin
                                    r_cfg_vld[widx] <= 1'b1;
                                    r_en[widx] <= (i_req.write_value[spmp_pkg::CFG_A_HI:
                                                   spmp_pkg::CFG_A_LO] != spmp_pkg::A_OFF);
                                end
                            end
                            spmp_pkg::OP_WR_ADR: begin
                                r_is_chk <= 1'b0;
                                r_state  <= S_FIN;
                                r_allow  <= idx_ok;
                                if (idx_ok) begin
                                    r_adr_vld[widx] <= 1'b1;
                                end
                            end
                            default: begin
                                // clear every A field
                                r_is_chk <= 1'b0;
                                r_state  <= S_FIN;
                                r_allow  <= 1'b1;
                                r_en     <= '0;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    // issue the next entry read
                    if (rd_en) begin
                        r_ridx <= r_ridx + CW'(1);
                        r_eidx <= r_ridx[IW-1:0];
                    end
                    // evaluate the entry read last cycle
                    if (r_evv) begin
                        r_prev_top <= e_top;
                    end
                    if (r_evv && e_hit) begin
                        r_allow <= decide(e_cfg, r_kind, r_priv, r_sum);
                        r_state <= S_FIN;
                        r_evv   <= 1'b0;
                    end else if (r_evv && r_eidx == IW'(ENTRIES - 1)) begin
                        r_allow <= 1'b0;
                        r_state <= S_FIN;
                        r_evv   <= 1'b0;
                    end else begin
                        r_evv <= rd_en;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_ok   <= r_allow;
                        r_out_code <= (r_is_chk && !r_allow) ? kind_code : spmp_pkg::FC_NONE;
                        r_out_addr <= (r_is_chk && !r_allow) ? r_fault_addr : '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Response side
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.fault_code = r_out_code;
    assign o_rsp.fault_addr = r_out_addr;
endmodule

### hdl/spmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
